// File: hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

  // Command codes carried in the input item
  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_RSTART = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_WRITE  = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  // Sequencer phases, one-hot
  typedef enum logic [23:0] {
    PH_IDLE = 24'h000001,
    PH_S0   = 24'h000002,
    PH_S1   = 24'h000004,
    PH_S2   = 24'h000008,
    PH_R0   = 24'h000010,
    PH_R1   = 24'h000020,
    PH_R2   = 24'h000040,
    PH_R3   = 24'h000080,
    PH_R4   = 24'h000100,
    PH_T0   = 24'h000200,
    PH_T1   = 24'h000400,
    PH_T2   = 24'h000800,
    PH_T3   = 24'h001000,
    PH_W0   = 24'h002000,
    PH_W1   = 24'h004000,
    PH_W2   = 24'h008000,
    PH_W3   = 24'h010000,
    PH_W4   = 24'h020000,
    PH_W5   = 24'h040000,
    PH_D0   = 24'h080000,
    PH_D1   = 24'h100000,
    PH_D2   = 24'h200000,
    PH_D3   = 24'h400000,
    PH_D4   = 24'h800000
  } phase_t;

  localparam logic [3:0]  BIT_LAST   = 4'd7;
  localparam logic [3:0]  BIT_COUNT  = 4'd8;
  localparam int unsigned BYTE_MSB   = 7;
  localparam logic [15:0] QP_RESET   = 16'd10;

  // Classified item handed from the front to the back through the queue
  typedef struct packed {
    logic       cmd_ok;
    phase_t     start_ph;
    logic [2:0] req;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       nacked;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive_low;
    logic       scl_drive_low;
  } result_t;

endpackage

// File: hw/rtl/i2cm_front.sv
// Front end: unpacks input items and classifies the command.
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic [15:0] in_tdata,
  input  logic [3:0]  in_tuser,
  output item_t       item
);

  logic [2:0] req;
  phase_t     start_ph;

  assign req = in_tuser[3:1];

  // Map the command to the first phase of its sequence; unknown codes stay idle
  always_comb begin
    unique case (req)
      REQ_START:  start_ph = PH_S0;
      REQ_RSTART: start_ph = PH_R0;
      REQ_STOP:   start_ph = PH_T0;
      REQ_WRITE:  start_ph = PH_W0;
      REQ_READ:   start_ph = PH_D0;
      default:    start_ph = PH_IDLE;
    endcase
  end

  assign item.cmd_ok    = in_tuser[0] && (start_ph != PH_IDLE);
  assign item.start_ph  = start_ph;
  assign item.req       = req;
  assign item.tx_byte   = in_tdata[7:0];
  assign item.send_nack = in_tdata[8];
  assign item.sda_in    = in_tdata[9];

endmodule

// File: hw/rtl/i2cm_queue.sv
// Small register FIFO between the front and the back.
module i2cm_queue
  import i2cm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/i2cm_back.sv
// Back end: quarter-bit sequencer that drives the bus and a registered result stage.
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] quarter_period,
  input  logic        q_empty,
  input  item_t       item,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [1:0]  ql_r, ql_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        nack_r, nack_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic        fin;
  result_t     res;

  logic        out_valid_r;
  result_t     out_res_r;

  // Take one item whenever the result stage is free or being drained
  assign pop = !q_empty && (!out_valid_r || out_tready);

  // One tick of the sequencer
  always_comb begin
    logic        act;
    phase_t      act_ph;
    logic [15:0] q;
    logic [15:0] tc;

    act         = 1'b0;
    act_ph      = phase_r;
    q           = (quarter_period == '0) ? 16'd1 : quarter_period;
    tc          = tick_r + 16'd1;
    fin         = 1'b0;
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    ql_nxt      = ql_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    nack_nxt    = nack_r;
    cmd_nxt     = cmd_r;

    // Decide whether an action runs on this tick
    if (phase_r == PH_IDLE) begin
      if (item.cmd_ok) begin
        cmd_nxt = item.req;
        act     = 1'b1;
        act_ph  = item.start_ph;
        if (item.req == REQ_WRITE) begin
          shift_nxt = item.tx_byte;
          nack_nxt  = 1'b0;
        end else if (item.req == REQ_READ) begin
          nack_nxt = item.send_nack;
        end
      end
    end else if (ql_r == 2'd0) begin
      act = 1'b1;
    end else begin
      tick_nxt = tc;
      if (tc >= q || tc == 16'd0) begin
        tick_nxt = '0;
        ql_nxt   = ql_r - 2'd1;
        act      = (ql_nxt == 2'd0);
      end
    end

    // Line actions; each wait restarts the quarter counter
    if (act) begin
      unique case (act_ph)
        PH_S0: begin
          scl_nxt = 1'b0; sda_nxt = 1'b0;
          ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_S1;
        end
        PH_S1: begin
          sda_nxt = 1'b1; ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_S2;
        end
        PH_S2: begin
          scl_nxt = 1'b1; fin = 1'b1;
        end
        PH_R0: begin
          sda_nxt = 1'b0; ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_R1;
        end
        PH_R1: begin
          scl_nxt = 1'b0; ql_nxt = 2'd1; tick_nxt = '0; phase_nxt = PH_R2;
        end
        PH_R2: begin
          sda_nxt = 1'b1; ql_nxt = 2'd1; tick_nxt = '0; phase_nxt = PH_R3;
        end
        PH_R3: begin
          scl_nxt = 1'b1; ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_R4;
        end
        PH_R4: fin = 1'b1;
        PH_T0: begin
          sda_nxt = 1'b1; ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_T1;
        end
        PH_T1: begin
          scl_nxt = 1'b0; ql_nxt = 2'd1; tick_nxt = '0; phase_nxt = PH_T2;
        end
        PH_T2: begin
          sda_nxt = 1'b0; ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_T3;
        end
        PH_T3: fin = 1'b1;
        PH_W0: begin
          bit_idx_nxt = BIT_LAST;
          sda_nxt     = ~shift_nxt[BYTE_MSB];
          ql_nxt = 2'd1; tick_nxt = '0; phase_nxt = PH_W1;
        end
        PH_W1: begin
          scl_nxt = 1'b0; ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_W2;
        end
        PH_W2: begin
          scl_nxt = 1'b1;
          if (bit_idx_r != 4'd0) begin
            bit_idx_nxt = bit_idx_r - 4'd1;
            shift_nxt   = {shift_r[6:0], 1'b0};
            sda_nxt     = ~shift_nxt[BYTE_MSB];
            ql_nxt = 2'd1; tick_nxt = '0; phase_nxt = PH_W1;
          end else begin
            // release SDA for the slave acknowledge
            sda_nxt = 1'b0;
            ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_W3;
          end
        end
        PH_W3: begin
          scl_nxt  = 1'b0;
          nack_nxt = item.sda_in;
          ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_W4;
        end
        PH_W4: begin
          scl_nxt = 1'b1; ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_W5;
        end
        PH_W5: fin = 1'b1;
        PH_D0: begin
          bit_idx_nxt = BIT_COUNT;
          shift_nxt   = '0;
          sda_nxt     = 1'b0;
          ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_D1;
        end
        PH_D1: begin
          scl_nxt     = 1'b0;
          shift_nxt   = {shift_r[6:0], item.sda_in};
          bit_idx_nxt = bit_idx_r - 4'd1;
          ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_D2;
        end
        PH_D2: begin
          scl_nxt = 1'b1;
          if (bit_idx_r != 4'd0) begin
            ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_D1;
          end else begin
            // master answers ACK (pull low) or NACK (release)
            sda_nxt = ~nack_r;
            ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_D3;
          end
        end
        PH_D3: begin
          scl_nxt = 1'b0; ql_nxt = 2'd2; tick_nxt = '0; phase_nxt = PH_D4;
        end
        PH_D4: begin
          scl_nxt = 1'b1; sda_nxt = 1'b0; fin = 1'b1;
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        phase_nxt = PH_IDLE;
        ql_nxt    = 2'd0;
        tick_nxt  = '0;
      end
    end
  end

  // Result fields
  always_comb begin
    res.scl_drive_low = scl_nxt;
    res.sda_drive_low = sda_nxt;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = fin;
    res.nacked        = (fin && cmd_nxt == REQ_WRITE) ? nack_nxt : 1'b0;
    res.rx_byte       = (fin && cmd_nxt == REQ_READ) ? shift_nxt : 8'd0;
  end

  // Sequencer state, advanced once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      ql_r      <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
      scl_r     <= 1'b0;
      sda_r     <= 1'b0;
      nack_r    <= 1'b0;
      cmd_r     <= '0;
    end else if (pop) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      ql_r      <= ql_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      nack_r    <= nack_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

endmodule

// File: hw/rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: configuration register, front, queue and back.
// Each input item is one tick of the bus timing; the engine takes one item per clock cycle
// while in_tready is high and returns exactly one result item per input item, in order.
// An accepted item enters a short queue and is popped when the result stage is free or being
// drained, and its result is registered in the output register as it is popped; the sustained
// rate of one item per cycle comes from one sequencer tick per popped item. The quarter
// period register may be written only while no command sequence is in progress.
module i2c_master_bit_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], send_nack[8], sda_in[9], zero[15:10]
  input  logic [3:0]  in_tuser,   // cmd_valid[0], req_type[3:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_drive_low[0], sda_drive_low[1], busy_res[2],
                                  // done_res[3], nacked[4], rx_byte[12:5], zero[15:13]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_QP = 1'b0;

  logic [15:0] qp_r;
  item_t       in_item, q_item;
  logic        q_full, q_empty, q_pop, q_push;

  // Configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_r <= QP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_QP) begin
      qp_r <= cfg_pwdata[15:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_QP) ? {16'd0, qp_r} : 32'd0;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  i2cm_front u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .item     (in_item)
  );

  i2cm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (in_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  i2cm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .quarter_period (qp_r),
    .q_empty        (q_empty),
    .item           (q_item),
    .pop            (q_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule

// File: hw/rtl/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A completing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && out_tdata[2]))
    else $error("done and busy together");

  // Ack flag and received byte are zero except on a done tick
  a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[12:4] == 9'd0)
    else $error("result fields set without done");

  // A done tick that follows an accepted non-busy tick does not report busy
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tdata[2] ##1 out_tvalid && out_tdata[3]
      |-> out_tdata[2] == 1'b0)
    else $error("done reported while busy");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);
